### design/kfli_pkg.sv
// Shared types and constants of the keyframe linear interpolator.
`default_nettype none

package kfli_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int KEY_COUNT_W  = 7;
  localparam int SLOT_W       = 6;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int IN_TDATA_W   = 168;
  localparam int OUT_TDATA_W  = 104;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_SEARCH,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] kz;
    logic [DATA_W-1:0] ky;
    logic [DATA_W-1:0] kx;
    logic [DATA_W-1:0] ktime;
  } key_t;

endpackage

`default_nettype wire

### design/keyframe_linear_interpolator.sv
// Usage notes: in_ beats either write one keyframe (tuser low) or ask for the value at a
// time (tuser high). A write is stored in the cycle it is accepted and gives no result.
// A query makes one out_ beat with the interpolated vector, the segment start index and
// a clamp flag. The cfg_ channel sets the number of keys in use and is always ready.
// A query walks the key table one RAM read per cycle until it finds the segment, then
// runs a serial divide for the fraction and uses one shared multiplier three times,
// with a multiply step and an add step per component. A single key or a clamped
// query skips the divide and multiply. in_tready stays low while a query is in
// progress. The result sits in an output register, so the next beat is accepted
// while it waits; if the receiver stalls, a finished query holds until the register
// is free. Reset clears the control state and sets the key count to one; table
// contents are undefined until written.
`default_nettype none

module keyframe_linear_interpolator
  import kfli_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: key_slot, key_time, key_value_x, key_value_y, key_value_z,
  // query_time, zero padding.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: opcode.
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: result_x, result_y, result_z, segment, clamped, zero padding.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [KEY_COUNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int KEY_W = $bits(key_t);
  localparam logic [KEY_COUNT_W-1:0] KEY_CAP =
    (MAX_KEYS > 127) ? KEY_COUNT_W'(127) : KEY_COUNT_W'(MAX_KEYS);
  localparam int PROD_W = DATA_W + FRAC_W + 2;

  state_t                  state_r, state_nxt;
  logic [KEY_COUNT_W-1:0]  key_count_r;
  logic [DATA_W-1:0]       q_r, q_nxt;
  logic [KEY_COUNT_W-1:0]  n_r, n_nxt;
  logic [KEY_COUNT_W-1:0]  idx_r, idx_nxt;
  logic [KEY_COUNT_W-1:0]  seg_r, seg_nxt;
  logic                    clamp_r, clamp_nxt;
  logic [DATA_W-1:0]       t1_r, t1_nxt;
  logic [DATA_W-1:0]       end_r [3];
  logic [DATA_W-1:0]       end_nxt [3];
  logic [DATA_W-1:0]       start_r [3];
  logic [DATA_W-1:0]       start_nxt [3];
  logic signed [DATA_W:0]  diff_r [3];
  logic signed [DATA_W:0]  diff_nxt [3];
  logic [DATA_W-1:0]       res_r [3];
  logic [DATA_W-1:0]       res_nxt [3];
  logic [FRAC_W-1:0]       frac_r, frac_nxt;
  logic [1:0]              comp_r, comp_nxt;
  logic [DATA_W-1:0]       prod_r, prod_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  logic [KEY_COUNT_W-1:0]  kc_sat;
  logic [KEY_COUNT_W-1:0]  n_eff;
  logic [SLOT_W-1:0]       in_slot;
  logic [DATA_W-1:0]       in_query_time;
  key_t                    wr_key;
  key_t                    rd_key;
  logic [KEY_W-1:0]        ram_rdata;
  logic [AW-1:0]           rd_addr;
  logic                    ram_we;
  logic                    div_start;
  logic                    div_done;
  logic [FRAC_W-1:0]       div_quot;
  logic [DATA_W-1:0]       div_dividend;
  logic [DATA_W-1:0]       div_divisor;
  logic signed [PROD_W-1:0] mul_full;
  logic [DATA_W-1:0]       rd_vals [3];

  assign in_slot       = in_tdata[5:0];
  assign wr_key.ktime  = in_tdata[37:6];
  assign wr_key.kx     = in_tdata[69:38];
  assign wr_key.ky     = in_tdata[101:70];
  assign wr_key.kz     = in_tdata[133:102];
  assign in_query_time = in_tdata[165:134];

  assign rd_key    = key_t'(ram_rdata);
  assign rd_vals[0] = rd_key.kx;
  assign rd_vals[1] = rd_key.ky;
  assign rd_vals[2] = rd_key.kz;

  assign kc_sat = (key_count_r > KEY_CAP) ? KEY_CAP : key_count_r;
  assign n_eff  = (kc_sat == '0) ? KEY_COUNT_W'(1) : kc_sat;

  assign div_dividend = q_r - rd_key.ktime;
  assign div_divisor  = t1_r - rd_key.ktime;
  assign mul_full     = PROD_W'(diff_r[comp_r]) * PROD_W'($signed({1'b0, frac_r}));

  kfli_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_KEYS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_slot)),
    .wdata(wr_key),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  kfli_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    q_nxt         = q_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    seg_nxt       = seg_r;
    clamp_nxt     = clamp_r;
    t1_nxt        = t1_r;
    end_nxt       = end_r;
    start_nxt     = start_r;
    diff_nxt      = diff_r;
    res_nxt       = res_r;
    frac_nxt      = frac_r;
    comp_nxt      = comp_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_addr       = '0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    in_tready     = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (op_t'(in_tuser) == OP_WRITE) begin
            ram_we = (32'(in_slot) < MAX_KEYS);
          end else begin
            q_nxt     = in_query_time;
            n_nxt     = n_eff;
            clamp_nxt = 1'b0;
            seg_nxt   = '0;
            if (n_eff == KEY_COUNT_W'(1)) begin
              state_nxt = ST_SINGLE;
            end else begin
              rd_addr   = AW'(1);
              idx_nxt   = KEY_COUNT_W'(1);
              state_nxt = ST_SEARCH;
            end
          end
        end
      end
      ST_SINGLE: begin
        res_nxt   = rd_vals;
        state_nxt = ST_DONE;
      end
      ST_SEARCH: begin
        if (q_r < rd_key.ktime) begin
          seg_nxt   = idx_r - KEY_COUNT_W'(1);
          t1_nxt    = rd_key.ktime;
          end_nxt   = rd_vals;
          rd_addr   = AW'(idx_r - KEY_COUNT_W'(1));
          state_nxt = ST_START;
        end else if (idx_r == n_r - KEY_COUNT_W'(1)) begin
          seg_nxt   = idx_r;
          clamp_nxt = 1'b1;
          res_nxt   = rd_vals;
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + KEY_COUNT_W'(1);
          rd_addr = AW'(idx_r + KEY_COUNT_W'(1));
        end
      end
      ST_START: begin
        start_nxt = rd_vals;
        for (int c = 0; c < 3; c++) begin
          diff_nxt[c] = $signed({end_r[c][DATA_W-1], end_r[c]})
                      - $signed({rd_vals[c][DATA_W-1], rd_vals[c]});
        end
        comp_nxt = '0;
        if (q_r > rd_key.ktime) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          frac_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          frac_nxt  = div_quot;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = mul_full[DATA_W+FRAC_W-1:FRAC_W];
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        res_nxt[comp_r] = start_r[comp_r] + prod_r;
        if (comp_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, clamp_r, seg_r[SLOT_W-1:0], res_r[2], res_r[1], res_r[0]};
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      key_count_r <= KEY_COUNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        key_count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    seg_r      <= seg_nxt;
    clamp_r    <= clamp_nxt;
    t1_r       <= t1_nxt;
    end_r      <= end_nxt;
    start_r    <= start_nxt;
    diff_r     <= diff_nxt;
    res_r      <= res_nxt;
    frac_r     <= frac_nxt;
    comp_r     <= comp_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

### design/kfli_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module kfli_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/kfli_div.sv
// Restoring divider that yields the Q0.16 fraction one quotient bit per cycle.
`default_nettype none

module kfli_div
  import kfli_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic [FRAC_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend;
      den_nxt  = divisor;
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(FRAC_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? DATA_W'(rem_sh - {1'b0, den_r}) : rem_sh[DATA_W-1:0];
      quot_nxt = {quot_r[FRAC_W-2:0], ge};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

### design/kfli_checker.sv
// Port-level checks of the keyframe linear interpolator and their binding.
`default_nettype none

module kfli_checker
  import kfli_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result beat dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("Result data changed while stalled.");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_QUERY) |=> !in_tready)
    else $error("Input accepted right after a query beat.");

  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_WRITE) |=> in_tready)
    else $error("Input not ready after a keyframe write.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind keyframe_linear_interpolator kfli_checker u_kfli_checker (.*);

`default_nettype wire
